// File: rtl/omc_pkg.sv
// Package for the owner map area claim check block.
// Holds sizes, field widths, operation codes and the shared structs.
// No dependencies.
`default_nettype none

package omc_pkg;

  // Canvas and shape sizes.
  localparam int GRID_W     = 256;
  localparam int GRID_H     = 128;
  localparam int SHAPE_MAX  = 16;
  localparam int SHAPE_COLS = 16;
  localparam int COL_MAX    = (SHAPE_MAX < SHAPE_COLS) ? SHAPE_MAX : SHAPE_COLS;

  // Field widths of the channels.
  localparam int MODE_W     = 2;
  localparam int ROW_IDX_W  = 4;
  localparam int MASK_W     = SHAPE_COLS;
  localparam int POS_X_W    = 9;
  localparam int POS_Y_W    = 8;
  localparam int OWNER_W    = 6;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int GW_REG_W   = 9;
  localparam int GH_REG_W   = 8;

  // Derived widths.
  localparam int X_W       = $clog2(GRID_W);
  localparam int Y_W       = $clog2(GRID_H);
  localparam int ADDR_W    = X_W + Y_W;
  localparam int MAP_DEPTH = GRID_W * GRID_H;
  localparam int SI_W      = $clog2(SHAPE_MAX);
  localparam int CI_W      = $clog2(SHAPE_COLS);
  localparam int CNT_W     = $clog2(SHAPE_MAX + 1);
  localparam int W_EFF_W   = $clog2(GRID_W + 1);
  localparam int H_EFF_W   = $clog2(GRID_H + 1);
  localparam int CX_W      = POS_X_W + 2;
  localparam int CY_W      = POS_Y_W + 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_CHECK   = 2'd1,
    MODE_CLAIM   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  // Saturated canvas size seen by the sequencer.
  typedef struct packed {
    logic [W_EFF_W-1:0] width;
    logic [H_EFF_W-1:0] height;
  } grid_cfg_t;

  // Request from the sequencer to the owner map memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [OWNER_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Decision of the cell unit for one visited cell.
  typedef struct packed {
    logic               conflict;
    logic               we;
    logic [OWNER_W-1:0] wdata;
  } cell_res_t;

endpackage

`default_nettype wire

// File: rtl/omc_if.sv
// Channel interfaces of the owner map area claim check block.
// Valid/ready channels for items, results and configuration writes; uses omc_pkg.
`default_nettype none

interface omc_in_if;
  import omc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [ROW_IDX_W-1:0] row_index;
  logic [MASK_W-1:0]    row_mask;
  logic [POS_X_W-1:0]   pos_x;
  logic [POS_Y_W-1:0]   pos_y;
  logic [OWNER_W-1:0]   owner_id;
  logic [SIZE_W-1:0]    shape_rows;
  logic [SIZE_W-1:0]    shape_cols;

  modport source (
    output valid, mode, row_index, row_mask, pos_x, pos_y, owner_id, shape_rows,
           shape_cols,
    input  ready
  );
  modport sink (
    input  valid, mode, row_index, row_mask, pos_x, pos_y, owner_id, shape_rows,
           shape_cols,
    output ready
  );
endinterface

interface omc_out_if;
  import omc_pkg::*;
  logic              valid;
  logic              ready;
  logic              area_free;
  logic [MODE_W-1:0] done_mode;

  modport source (output valid, area_free, done_mode, input ready);
  modport sink   (input valid, area_free, done_mode, output ready);
endinterface

interface omc_cfg_if;
  import omc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/omc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module omc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/omc_cell_unit.sv
// Compare and update unit applied to one owner map cell per cycle.
// Depends on omc_pkg for the operation codes and the result struct.
`default_nettype none

module omc_cell_unit (
  input  wire omc_pkg::mode_t                 op,
  input  wire logic [omc_pkg::OWNER_W-1:0]    cell_owner,
  input  wire logic [omc_pkg::OWNER_W-1:0]    owner_id,
  output omc_pkg::cell_res_t                  res
);
  import omc_pkg::*;

  logic is_free;
  logic is_mine;

  assign is_free = (cell_owner == '0);
  assign is_mine = (cell_owner == owner_id);

  always_comb begin
    res = '0;
    case (op)
      MODE_CHECK: begin
        res.conflict = !is_free && !is_mine;
      end
      MODE_CLAIM: begin
        res.we    = 1'b1;
        res.wdata = owner_id;
      end
      MODE_RELEASE: begin
        // Only cells held by this owner go back to free.
        res.we    = is_mine;
        res.wdata = '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/omc_seq.sv
// Sequencer: owner map clearing pass, shape row storage and the cell walk that
// drives the owner map memory and the cell unit. Depends on omc_pkg, omc_if, omc_cell_unit.
`default_nettype none

module omc_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  omc_in_if.sink                             in_if,
  omc_out_if.source                          out_if,
  input  wire omc_pkg::grid_cfg_t            grid_cfg,
  output omc_pkg::ram_req_t                  ram_req,
  input  wire logic [omc_pkg::OWNER_W-1:0]   ram_rdata
);
  import omc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic [CNT_W-1:0]     rows_r, rows_nxt;
  logic [CNT_W-1:0]     cols_r, cols_nxt;
  logic [POS_X_W-1:0]   px_r, px_nxt;
  logic [POS_Y_W-1:0]   py_r, py_nxt;
  logic [OWNER_W-1:0]   id_r, id_nxt;
  mode_t                mode_r, mode_nxt;
  logic                 ok_r, ok_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0]    s1_addr_r, s1_addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free_r, out_free_nxt;
  logic [MODE_W-1:0]    out_mode_r, out_mode_nxt;

  logic [MASK_W-1:0]    shape_r [SHAPE_MAX];

  logic                 accept;
  mode_t                in_mode;
  logic [CNT_W-1:0]     rows_sat;
  logic [CNT_W-1:0]     cols_sat;
  logic [MASK_W-1:0]    row_bits;
  logic                 cell_solid;
  logic signed [CY_W-1:0] cy;
  logic signed [CX_W-1:0] cx;
  logic                 cy_ok;
  logic                 cx_ok;
  logic [ADDR_W-1:0]    cell_addr;
  logic                 last_col;
  logic                 last_row;
  cell_res_t            cell_res;

  assign in_mode = mode_t'(in_if.mode);
  assign accept  = in_if.valid && in_if.ready;

  assign rows_sat = (32'(in_if.shape_rows) > SHAPE_MAX) ? CNT_W'(SHAPE_MAX)
                                                        : CNT_W'(in_if.shape_rows);
  assign cols_sat = (32'(in_if.shape_cols) > COL_MAX) ? CNT_W'(COL_MAX)
                                                      : CNT_W'(in_if.shape_cols);

  // Address generation for the cell at (i_r, j_r) of the shape.
  assign row_bits   = shape_r[i_r[SI_W-1:0]];
  assign cell_solid = row_bits[j_r[CI_W-1:0]];
  assign cy = $signed({{(CY_W-POS_Y_W){py_r[POS_Y_W-1]}}, py_r}) + $signed(CY_W'(i_r));
  assign cx = $signed({{(CX_W-POS_X_W){px_r[POS_X_W-1]}}, px_r}) + $signed(CX_W'(j_r));
  assign cy_ok = !cy[CY_W-1] && (cy[CY_W-2:0] < (CY_W-1)'(grid_cfg.height));
  assign cx_ok = !cx[CX_W-1] && (cx[CX_W-2:0] < (CX_W-1)'(grid_cfg.width));
  assign cell_addr = {cy[Y_W-1:0], cx[X_W-1:0]};

  assign last_col = (j_r == cols_r - CNT_W'(1));
  assign last_row = (i_r == rows_r - CNT_W'(1));

  omc_cell_unit u_cell (
    .op         (mode_r),
    .cell_owner (ram_rdata),
    .owner_id   (id_r),
    .res        (cell_res)
  );

  always_comb begin
    ram_req.raddr = cell_addr;
    if (state_r == S_CLEAR) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_addr_r;
      ram_req.wdata = '0;
    end else begin
      ram_req.we    = s1_valid_r && cell_res.we;
      ram_req.waddr = s1_addr_r;
      ram_req.wdata = cell_res.wdata;
    end
  end

  assign in_if.ready      = (state_r == S_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.area_free = out_free_r;
  assign out_if.done_mode = out_mode_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    id_nxt        = id_r;
    mode_nxt      = mode_r;
    ok_nxt        = ok_r;
    s1_valid_nxt  = 1'b0;
    s1_addr_nxt   = s1_addr_r;
    out_valid_nxt = out_valid_r;
    out_free_nxt  = out_free_r;
    out_mode_nxt  = out_mode_r;

    // The second pipeline stage sees the read data of the cell issued last cycle.
    if (s1_valid_r && cell_res.conflict) begin
      ok_nxt = 1'b0;
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt = in_mode;
          px_nxt   = in_if.pos_x;
          py_nxt   = in_if.pos_y;
          id_nxt   = in_if.owner_id;
          rows_nxt = rows_sat;
          cols_nxt = cols_sat;
          i_nxt    = '0;
          j_nxt    = '0;
          ok_nxt   = 1'b1;
          if (in_mode == MODE_LOAD || rows_sat == '0 || cols_sat == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        s1_valid_nxt = cell_solid && cy_ok && cx_ok;
        s1_addr_nxt  = cell_addr;
        if (last_col) begin
          j_nxt = '0;
          if (last_row) begin
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + CNT_W'(1);
          end
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_free_nxt  = (mode_r == MODE_CHECK) ? ok_r : 1'b1;
          out_mode_nxt  = mode_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    id_r       <= id_nxt;
    mode_r     <= mode_nxt;
    ok_r       <= ok_nxt;
    s1_addr_r  <= s1_addr_nxt;
    out_free_r <= out_free_nxt;
    out_mode_r <= out_mode_nxt;
  end

  // Shape rows beyond the stored depth are dropped.
  always_ff @(posedge clk) begin
    if (accept && in_mode == MODE_LOAD && 32'(in_if.row_index) < SHAPE_MAX) begin
      shape_r[in_if.row_index[SI_W-1:0]] <= in_if.row_mask;
    end
  end

endmodule

`default_nettype wire

// File: rtl/owner_map_area_claim_check_top.sv
// Top level of the owner map area claim check block.
// Depends on omc_pkg, omc_if, omc_ram and omc_seq.
`default_nettype none

// Occupancy map of 256 x 128 cells, each holding a 6-bit owner ID (0 is free),
// plus a 16 x 16 shape mask loaded one row per load transaction. After reset
// a clearing pass writes every one of the 32768 map cells to zero, one cell
// per cycle, and no input transaction is taken during the clearing pass;
// configuration writes are always taken. A load transaction goes from the idle
// state through the finish state to its registered result. A check, claim or
// release walks the shape's rows times columns cells, one cell per cycle
// through the single read and single write port of the owner map memory,
// then passes through the drain and finish states; an empty shape goes
// straight to the finish state. One transaction is in work at a time; a new
// transaction is taken while the previous result still waits on the output.
module owner_map_area_claim_check_top (
  input wire logic  clk,
  input wire logic  rst_n,
  omc_in_if.sink    in_if,
  omc_out_if.source out_if,
  omc_cfg_if.sink   cfg_if
);
  import omc_pkg::*;

  logic [GW_REG_W-1:0] width_r, width_nxt;
  logic [GH_REG_W-1:0] height_r, height_nxt;
  grid_cfg_t           grid_cfg;
  ram_req_t            ram_req;
  logic [OWNER_W-1:0]  ram_rdata;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_GRID_WIDTH:  width_nxt  = cfg_if.data[GW_REG_W-1:0];
        REG_GRID_HEIGHT: height_nxt = cfg_if.data[GH_REG_W-1:0];
        default: begin
          width_nxt  = width_r;
          height_nxt = height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= GW_REG_W'(GRID_W);
      height_r <= GH_REG_W'(GRID_H);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Register values past the canvas size saturate to the full canvas.
  assign grid_cfg.width  = (32'(width_r) > GRID_W) ? W_EFF_W'(GRID_W) : W_EFF_W'(width_r);
  assign grid_cfg.height = (32'(height_r) > GRID_H) ? H_EFF_W'(GRID_H) : H_EFF_W'(height_r);

  omc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .grid_cfg  (grid_cfg),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  omc_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (OWNER_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
